// ===== src/essg_pkg.sv =====
package essg_pkg;

    localparam int INDEX_WIDTH      = 16;
    localparam int SINE_TABLE_DEPTH = 1024;
    localparam int EXP_TABLE_DEPTH  = 256;

    localparam int ExpAddrW = $clog2(EXP_TABLE_DEPTH);
    localparam int SinAddrW = $clog2(SINE_TABLE_DEPTH);

    localparam logic [63:0] Log2eQ31  = 64'd3098164009;
    localparam logic [63:0] Ln2Q30    = 64'd744261118;
    localparam logic [63:0] HalfpiQ30 = 64'd1686629713;
    localparam logic [63:0] Q30One    = 64'd1 << 30;

    localparam logic [46:0] Gm1Sat = (47'd1 << 46) - (47'd1 << 30);

    localparam int CfgIndexW = 8;
    localparam logic [CfgIndexW-1:0] CfgPhaseTurns = 8'd0;
    localparam logic [CfgIndexW-1:0] CfgGrowthRate = 8'd1;

    typedef logic [31:0] t_exp_rom [EXP_TABLE_DEPTH+1];
    typedef logic [30:0] t_sin_rom [SINE_TABLE_DEPTH+1];

    typedef struct packed {
        logic en;
        logic valid;
    } t_ctl;

    function automatic logic [63:0] f_exp_q30(input logic [63:0] t);
        logic [63:0] sum;
        logic [63:0] term;
        sum  = Q30One;
        term = Q30One;
        for (int n = 1; n <= 20; n++) begin
            term = ((term * t) >> 30) / 64'(n);
            sum  = sum + term;
        end
        return sum;
    endfunction

    function automatic logic [63:0] f_sin_q30(input logic [63:0] a);
        longint      sum;
        logic [63:0] term;
        sum  = longint'(a);
        term = a;
        for (int n = 1; n <= 12; n++) begin
            term = (term * a) >> 30;
            term = (term * a) >> 30;
            term = term / 64'((2 * n) * (2 * n + 1));
            if ((n % 2) == 1) begin
                sum = sum - longint'(term);
            end else begin
                sum = sum + longint'(term);
            end
        end
        if (sum < 0) begin
            sum = 0;
        end
        if (64'(sum) > Q30One) begin
            sum = longint'(Q30One);
        end
        return 64'(sum);
    endfunction

    function automatic t_exp_rom f_build_exp();
        t_exp_rom    rom;
        logic [63:0] v;
        for (int k = 0; k <= EXP_TABLE_DEPTH; k++) begin
            v = f_exp_q30(Ln2Q30 * 64'(k) / EXP_TABLE_DEPTH);
            rom[k] = v[31:0];
        end
        return rom;
    endfunction

    function automatic t_sin_rom f_build_sin();
        t_sin_rom    rom;
        logic [63:0] v;
        for (int k = 0; k <= SINE_TABLE_DEPTH; k++) begin
            v = f_sin_q30(HalfpiQ30 * 64'(k) / SINE_TABLE_DEPTH);
            rom[k] = v[30:0];
        end
        return rom;
    endfunction

    localparam t_exp_rom ExpRom = f_build_exp();
    localparam t_sin_rom SinRom = f_build_sin();

endpackage

// ===== src/essg_growth.sv =====
module essg_growth (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  essg_pkg::t_ctl                   i_ctl,
    input  logic [essg_pkg::INDEX_WIDTH-1:0] i_index,
    input  logic [31:0]                      i_rate,
    output logic                             o_valid,
    output logic [46:0]                      o_gm1
);
    import essg_pkg::*;

    localparam int XW = 32 + INDEX_WIDTH;

    logic [4:0]          r_v;
    logic [XW-1:0]       r_x;
    logic [36:0]         r_y;
    logic                r_sat2;
    logic [31:0]         r_e0_3;
    logic [31:0]         r_e1_3;
    logic [31:0]         r_frac3;
    logic [4:0]          r_n3;
    logic                r_sat3;
    logic [31:0]         r_e0_4;
    logic [31:0]         r_step4;
    logic                r_dir4;
    logic [4:0]          r_n4;
    logic                r_sat4;
    logic [46:0]         r_gm1;

    logic [63:0]         n_ymul;
    logic                n_xsat;
    logic [ExpAddrW-1:0] n_eidx;
    logic [ExpAddrW:0]   n_eidx1;
    logic [31:0]         n_diff;
    logic                n_dir;
    logic [63:0]         n_prod;
    logic [31:0]         n_mant;
    logic [46:0]         n_shift;

    always_comb begin
        n_xsat  = (r_x >> 36) != '0;
        n_ymul  = 64'(r_x[35:4]) * Log2eQ31;
        n_eidx  = r_y[31 -: ExpAddrW];
        n_eidx1 = {1'b0, n_eidx} + 1'b1;
        n_dir   = r_e1_3 >= r_e0_3;
        n_diff  = n_dir ? (r_e1_3 - r_e0_3) : (r_e0_3 - r_e1_3);
        n_prod  = 64'(n_diff) * 64'(r_frac3);
        n_mant  = r_dir4 ? (r_e0_4 + r_step4) : (r_e0_4 - r_step4);
        n_shift = 47'(n_mant) << r_n4[3:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_ctl.en) begin
            r_v <= {r_v[3:0], i_ctl.valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en) begin
            r_x     <= XW'(i_rate) * XW'(i_index);
            r_y     <= n_ymul[63:27];
            r_sat2  <= n_xsat;
            r_e0_3  <= ExpRom[n_eidx];
            r_e1_3  <= ExpRom[n_eidx1];
            r_frac3 <= {r_y[31-ExpAddrW:0], {ExpAddrW{1'b0}}};
            r_n3    <= r_y[36:32];
            r_sat3  <= r_sat2 || r_y[36];
            r_e0_4  <= r_e0_3;
            r_step4 <= n_prod[63:32];
            r_dir4  <= n_dir;
            r_n4    <= r_n3;
            r_sat4  <= r_sat3;
            r_gm1   <= r_sat4 ? Gm1Sat : (n_shift - 47'(Q30One));
        end
    end

    assign o_valid = r_v[4];
    assign o_gm1   = r_gm1;

`ifndef SYNTH
    a_gm1_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_gm1 <= Gm1Sat))
        else $error("growth factor out of range");
    a_sat_path: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_ctl.en && r_v[3] && r_sat4) |=> (r_gm1 == Gm1Sat))
        else $error("saturated growth factor not applied");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_ctl.en |=> $stable(r_v) && $stable(r_gm1))
        else $error("growth pipeline moved while stalled");
`endif

endmodule

// ===== src/exponential_sine_sweep_generator_unit.sv =====
// Exponential sine sweep generator.
// Input channel: i_in_valid / o_in_ready carry a sample index; only the low
// INDEX_WIDTH bits are used. Output channel: o_out_valid / i_out_ready carry
// one signed 24-bit sweep sample per accepted index, in order.
// Configuration channel: i_cfg_valid / o_cfg_ready with i_cfg_index and
// i_cfg_data; index 0 writes phase_turns, index 1 writes growth_rate, other
// indexes are ignored. Write only while no sample is in flight.
// The datapath is an 11-stage pipeline: five stages form the growth factor
// (multiply, log2(e) scaling, exp table read, interpolation, shift), then
// two phase multiplies, the quarter-wave mirror, sine table read,
// interpolation and the output register.
// Throughput is one sample per cycle while the receiver takes every sample.
// When the receiver stalls, the whole pipeline holds and o_in_ready falls
// until the waiting sample is transferred; nothing is lost or repeated.
// Synchronous reset clears all valid bits and loads the register defaults.
module exponential_sine_sweep_generator_unit (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic [15:0]                       i_sample_index,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic signed [23:0]                o_sample,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [essg_pkg::CfgIndexW-1:0]    i_cfg_index,
    input  logic [31:0]                       i_cfg_data
);
    import essg_pkg::*;

    logic [31:0]         r_phase_turns;
    logic [31:0]         r_growth_rate;
    logic [5:0]          r_v;
    logic [55:0]         r_plo;
    logic [54:0]         r_phi;
    logic [31:0]         r_phase;
    logic [SinAddrW-1:0] r_addr;
    logic                r_last;
    logic [29:0]         r_sfrac3;
    logic                r_neg3;
    logic [30:0]         r_s0;
    logic [30:0]         r_s1;
    logic [29:0]         r_sfrac4;
    logic                r_neg4;
    logic [30:0]         r_s0_5;
    logic [30:0]         r_step5;
    logic                r_dir5;
    logic                r_neg5;
    logic signed [23:0]  r_sample;

    t_ctl                ctl;
    logic                g_valid;
    logic [46:0]         g_gm1;
    logic [53:0]         n_sum;
    logic [30:0]         n_r;
    logic [SinAddrW:0]   n_sidx;
    logic [SinAddrW:0]   n_addr1;
    logic                n_dir;
    logic [30:0]         n_diff;
    logic [60:0]         n_prod;
    logic [30:0]         n_mag;
    logic [23:0]         n_val;

    assign ctl.en      = !r_v[5] || i_out_ready;
    assign ctl.valid   = i_in_valid;
    assign o_in_ready  = ctl.en;
    assign o_cfg_ready = 1'b1;

    essg_growth u_growth (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (ctl),
        .i_index (i_sample_index[INDEX_WIDTH-1:0]),
        .i_rate  (r_growth_rate),
        .o_valid (g_valid),
        .o_gm1   (g_gm1)
    );

    always_comb begin
        n_sum   = r_plo[53:0] + {r_phi[29:0], 24'd0};
        n_r     = r_phase[30] ? (31'(Q30One) - {1'b0, r_phase[29:0]})
                              : {1'b0, r_phase[29:0]};
        n_sidx  = n_r[30 -: SinAddrW+1];
        n_addr1 = {1'b0, r_addr} + 1'b1;
        n_dir   = r_s1 >= r_s0;
        n_diff  = n_dir ? (r_s1 - r_s0) : (r_s0 - r_s1);
        n_prod  = 61'(n_diff) * 61'(r_sfrac4);
        n_mag   = r_dir5 ? (r_s0_5 + r_step5) : (r_s0_5 - r_step5);
        n_val   = {1'b0, n_mag[30:8]};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase_turns <= 32'd95716030;
            r_growth_rate <= 32'd1176293;
            r_v           <= '0;
        end else begin
            if (i_cfg_valid && (i_cfg_index == CfgPhaseTurns)) begin
                r_phase_turns <= i_cfg_data;
            end
            if (i_cfg_valid && (i_cfg_index == CfgGrowthRate)) begin
                r_growth_rate <= i_cfg_data;
            end
            if (ctl.en) begin
                r_v <= {r_v[4:0], g_valid};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (ctl.en) begin
            r_plo    <= 56'(r_phase_turns) * 56'(g_gm1[23:0]);
            r_phi    <= 55'(r_phase_turns) * 55'(g_gm1[46:24]);
            r_phase  <= n_sum[53:22];
            r_addr   <= n_sidx[SinAddrW-1:0];
            r_last   <= n_sidx[SinAddrW];
            r_sfrac3 <= {n_r[29-SinAddrW:0], {SinAddrW{1'b0}}};
            r_neg3   <= r_phase[31];
            r_s0     <= r_last ? SinRom[SINE_TABLE_DEPTH] : SinRom[r_addr];
            r_s1     <= r_last ? SinRom[SINE_TABLE_DEPTH] : SinRom[n_addr1];
            r_sfrac4 <= r_sfrac3;
            r_neg4   <= r_neg3;
            r_s0_5   <= r_s0;
            r_step5  <= n_prod[60:30];
            r_dir5   <= n_dir;
            r_neg5   <= r_neg4;
            r_sample <= r_neg5 ? -n_val : n_val;
        end
    end

    assign o_out_valid = r_v[5];
    assign o_sample    = r_sample;

`ifndef SYNTH
    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_sample <= 24'sd4194304 && o_sample >= -24'sd4194304))
        else $error("sample out of range");
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> (o_out_valid && !i_out_ready))
        else $error("input stalled without a waiting sample");
    a_mirror: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (ctl.en && r_v[2] && r_last) |=> (r_s0 == r_s1))
        else $error("quarter endpoint not taken from last entry");
`endif

endmodule
